// ----- hw/rtl/modexp_pkg.sv -----
package modexp_pkg;

    localparam int DEFAULT_MOD_WIDTH = 32;
    localparam int BASE_W = 64;
    localparam int POW_W = 64;
    localparam int DIV_W = 32;
    localparam int RES_W = 31;

    typedef struct packed {
        logic signed [BASE_W-1:0] base_value;
        logic signed [POW_W-1:0]  power;
        logic signed [DIV_W-1:0]  divisor_modulus;
    } modexp_in_t;

    typedef struct packed {
        logic [RES_W-1:0] residue;
        logic             error_flag;
    } modexp_out_t;

    // datapath operations
    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_RBASE  = 3'd1;
    localparam logic [2:0] OP_EUCLID = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_SQR    = 3'd4;
    localparam logic [2:0] OP_FIXINV = 3'd5;
    localparam logic [2:0] OP_NONE   = 3'd6;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } modexp_cmd_t;

    typedef struct packed {
        logic busy;
        logic m_zero;
        logic m_one;
        logic exp_neg;
        logic exp_zero;
        logic exp_lsb;
        logic euclid_done;
        logic inv_ok;
    } modexp_sts_t;

endpackage

// ----- hw/rtl/modexp_datapath.sv -----
module modexp_datapath
    import modexp_pkg::*;
#(
    parameter int MOD_WIDTH = DEFAULT_MOD_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  modexp_in_t  in_data,
    input  modexp_cmd_t cmd,
    output modexp_sts_t sts,
    output logic [RES_W-1:0] residue
);

    localparam int MW = MOD_WIDTH;
    localparam int PW = 2 * MW;
    localparam int RW = 66;

    logic [MW-1:0]  m_reg, m_next;
    logic [MW-1:0]  aux_reg, aux_next;
    logic [MW-1:0]  ans_reg, ans_next;
    logic [POW_W-1:0] e_reg, e_next;
    logic           neg_reg, neg_next;
    logic [BASE_W-1:0] braw_reg, braw_next;
    logic           bneg_reg, bneg_next;
    // shared restoring divider: remainder of num by den, one bit a cycle
    logic [RW-1:0]  num_reg, num_next;
    logic [MW:0]    rem_reg, rem_next;
    logic [6:0]     cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic [RW-1:0]  quo_reg, quo_next;
    logic [2:0]     dst_reg, dst_next;
    // extended Euclid: r0,r1,s0,s1 (s signed, magnitude below m)
    logic [MW-1:0]  r0_reg, r0_next, r1_reg, r1_next;
    logic signed [MW+1:0] s0_reg, s0_next, s1_reg, s1_next;
    logic [MW-1:0]  mulq_a;
    logic signed [MW+1:0] mulq_p;

    logic [MW-1:0] mbits;
    logic [MW:0]   rem_sh;
    logic [MW-1:0] ed_q;

    assign mbits = in_data.divisor_modulus[MW-1:0];
    assign rem_sh = {rem_reg[MW-1:0], num_reg[RW-1]};
    assign ed_q = quo_reg[MW-1:0];
    assign mulq_a = ed_q;
    assign mulq_p = $signed({2'b00, mulq_a}) * s1_reg;

    assign sts.busy = busy_reg;
    assign sts.m_zero = (m_reg == '0);
    assign sts.m_one = (m_reg == MW'(1));
    assign sts.exp_neg = neg_reg;
    assign sts.exp_zero = (e_reg == '0);
    assign sts.exp_lsb = e_reg[0];
    assign sts.euclid_done = (r1_reg == '0);
    assign sts.inv_ok = (r0_reg == MW'(1));
    assign residue = RES_W'(ans_reg);

    always_comb begin
        m_next = m_reg; aux_next = aux_reg; ans_next = ans_reg; e_next = e_reg;
        neg_next = neg_reg; braw_next = braw_reg; bneg_next = bneg_reg;
        num_next = num_reg; rem_next = rem_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; quo_next = quo_reg; dst_next = dst_reg;
        r0_next = r0_reg; r1_next = r1_reg; s0_next = s0_reg; s1_next = s1_reg;
        if (busy_reg) begin
            if (rem_sh >= {1'b0, m_reg} && dst_reg != OP_EUCLID) begin
                rem_next = rem_sh - {1'b0, m_reg};
                quo_next = {quo_reg[RW-2:0], 1'b1};
            end else if (dst_reg == OP_EUCLID && rem_sh >= {1'b0, r1_reg}) begin
                rem_next = rem_sh - {1'b0, r1_reg};
                quo_next = {quo_reg[RW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[RW-2:0], 1'b0};
            end
            num_next = {num_reg[RW-2:0], 1'b0};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
            end
        end else if (dst_reg != OP_NONE) begin
            // write back finished reduction
            dst_next = OP_NONE;
            unique case (dst_reg)
                OP_RBASE: begin
                    // the reduced base also seeds the Euclid remainder
                    if (bneg_reg && rem_reg != '0) begin
                        aux_next = m_reg - rem_reg[MW-1:0];
                        r0_next = m_reg - rem_reg[MW-1:0];
                    end else begin
                        aux_next = rem_reg[MW-1:0];
                        r0_next = rem_reg[MW-1:0];
                    end
                end
                OP_MUL:    ans_next = rem_reg[MW-1:0];
                OP_SQR:    aux_next = rem_reg[MW-1:0];
                OP_EUCLID: begin
                    r0_next = r1_reg;
                    r1_next = rem_reg[MW-1:0];
                    s0_next = s1_reg;
                    s1_next = s0_reg - mulq_p;
                end
                default: ;
            endcase
        end else if (cmd.start) begin
            unique case (cmd.op)
                OP_LOAD: begin
                    m_next = mbits[MW-1] ? MW'(-mbits) : mbits;
                    neg_next = in_data.power[POW_W-1];
                    e_next = in_data.power[POW_W-1] ? -in_data.power : in_data.power;
                    bneg_next = in_data.base_value[BASE_W-1];
                    braw_next = in_data.base_value[BASE_W-1] ? -in_data.base_value
                                                             : in_data.base_value;
                    ans_next = MW'(1);
                end
                OP_RBASE: begin
                    num_next = RW'(braw_reg);
                    rem_next = '0; cnt_next = 7'(RW); busy_next = 1'b1;
                    dst_next = OP_RBASE;
                    r0_next = '0; r1_next = m_reg;
                    s0_next = 'sd1; s1_next = '0;
                end
                OP_EUCLID: begin
                    num_next = RW'(r0_reg) << (RW - MW);
                    rem_next = '0; cnt_next = 7'(MW); busy_next = 1'b1;
                    quo_next = '0; dst_next = OP_EUCLID;
                end
                OP_MUL: begin
                    num_next = RW'({{MW{1'b0}}, ans_reg} * {{MW{1'b0}}, aux_reg})
                               << (RW - PW);
                    rem_next = '0; cnt_next = 7'(PW); busy_next = 1'b1;
                    dst_next = OP_MUL;
                end
                OP_SQR: begin
                    num_next = RW'({{MW{1'b0}}, aux_reg} * {{MW{1'b0}}, aux_reg})
                               << (RW - PW);
                    rem_next = '0; cnt_next = 7'(PW); busy_next = 1'b1;
                    dst_next = OP_SQR;
                    e_next = e_reg >> 1;
                end
                OP_FIXINV: begin
                    aux_next = s0_reg[MW+1] ? MW'(s0_reg + $signed({2'b00, m_reg}))
                                            : MW'(s0_reg);
                    if (m_reg == MW'(1)) begin
                        aux_next = MW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            dst_reg <= OP_NONE;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            dst_reg <= dst_next;
            cnt_reg <= cnt_next;
        end
        m_reg <= m_next; aux_reg <= aux_next; ans_reg <= ans_next; e_reg <= e_next;
        neg_reg <= neg_next; braw_reg <= braw_next; bneg_reg <= bneg_next;
        num_reg <= num_next; rem_reg <= rem_next; quo_reg <= quo_next;
        r0_reg <= r0_next; r1_reg <= r1_next; s0_reg <= s0_next; s1_reg <= s1_next;
    end

endmodule

// ----- hw/rtl/modexp_ctrl.sv -----
module modexp_ctrl
    import modexp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        err,
    input  modexp_sts_t sts,
    output modexp_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHK   = 4'd1;
    localparam logic [3:0] ST_RED   = 4'd2;
    localparam logic [3:0] ST_EUC   = 4'd3;
    localparam logic [3:0] ST_FIX   = 4'd4;
    localparam logic [3:0] ST_LOOP  = 4'd5;
    localparam logic [3:0] ST_SQR   = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;
    localparam logic [3:0] ST_WAIT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       err_reg, err_next;
    logic       pend_reg, pend_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign err = err_reg;

    always_comb begin
        state_next = state_reg;
        err_next = err_reg;
        pend_next = pend_reg;
        cmd.start = 1'b0;
        cmd.op = OP_NONE;
        // datapath is busy while pend_reg or sts.busy; wait for writeback
        if (pend_reg) begin
            if (!sts.busy) begin
                pend_next = 1'b0;
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd.start = 1'b1; cmd.op = OP_LOAD;
                        err_next = 1'b0;
                        state_next = ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (sts.m_zero) begin
                        err_next = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        cmd.start = 1'b1; cmd.op = OP_RBASE;
                        pend_next = 1'b1;
                        state_next = ST_RED;
                    end
                end
                ST_RED: begin
                    if (sts.exp_neg && !sts.m_one) begin
                        state_next = ST_EUC;
                    end else if (sts.exp_neg) begin
                        cmd.start = 1'b1; cmd.op = OP_FIXINV;
                        state_next = ST_LOOP;
                    end else begin
                        state_next = ST_LOOP;
                    end
                end
                ST_EUC: begin
                    if (sts.euclid_done) begin
                        state_next = ST_FIX;
                    end else begin
                        cmd.start = 1'b1; cmd.op = OP_EUCLID;
                        pend_next = 1'b1;
                    end
                end
                ST_FIX: begin
                    if (!sts.inv_ok) begin
                        err_next = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        cmd.start = 1'b1; cmd.op = OP_FIXINV;
                        state_next = ST_LOOP;
                    end
                end
                ST_LOOP: begin
                    if (sts.exp_zero) begin
                        state_next = ST_OUT;
                    end else if (sts.exp_lsb) begin
                        cmd.start = 1'b1; cmd.op = OP_MUL;
                        pend_next = 1'b1;
                        state_next = ST_SQR;
                    end else begin
                        state_next = ST_SQR;
                    end
                end
                ST_SQR: begin
                    cmd.start = 1'b1; cmd.op = OP_SQR;
                    pend_next = 1'b1;
                    state_next = ST_WAIT;
                end
                ST_WAIT: state_next = ST_LOOP;
                ST_OUT: begin
                    if (m_ready) begin
                        state_next = ST_IDLE;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            err_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            err_reg <= err_next;
            pend_reg <= pend_next;
        end
    end

endmodule

// ----- hw/rtl/modular_exponentiation_unit.sv -----
// Sequence: reduce the base, then for a negative power run Euclid steps for the
// inverse (unless the modulus is one), then per exponent bit one or two serial
// reductions (a multiply when the bit is set, then a square).
// Throughput: one item at a time; the shared bit-serial remainder unit sets it.
// Reset: aresetn synchronous active low; returns the controller to idle.
module modular_exponentiation_unit
    import modexp_pkg::*;
#(
    parameter int MOD_WIDTH = DEFAULT_MOD_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  modexp_in_t  s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output modexp_out_t m_data
);

    modexp_cmd_t cmd;
    modexp_sts_t sts;
    logic [RES_W-1:0] res;
    logic err;

    modexp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .err(err), .sts(sts), .cmd(cmd)
    );

    modexp_datapath #(.MOD_WIDTH(MOD_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_data(s_data), .cmd(cmd), .sts(sts), .residue(res)
    );

    assign m_data.residue = err ? '0 : res;
    assign m_data.error_flag = err;

endmodule

// ----- bench/modexp_checker.sv -----
module modexp_checker
    import modexp_pkg::*;
#(
    parameter int MOD_WIDTH = DEFAULT_MOD_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  modexp_in_t  s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  modexp_out_t m_data,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          errors_seen
);

    modexp_out_t residue_queue[$];

    // Extended Euclid; returns 0 when gcd(a, m) != 1.
    function automatic bit modinv(input logic [63:0] a, input logic [63:0] m,
                                  output logic [63:0] inv);
        longint r0, r1, s0, s1, q, nr, ns;
        r0 = a;
        r1 = m;
        s0 = 1;
        s1 = 0;
        inv = '0;
        while (r1 > 0) begin
            q = r0 / r1;
            nr = r0 - q * r1;
            ns = s0 - q * s1;
            r0 = r1;
            r1 = nr;
            s0 = s1;
            s1 = ns;
        end
        if (r0 != 1) return 0;
        s0 = s0 % longint'(m);
        if (s0 < 0) s0 = s0 + longint'(m);
        inv = s0;
        return 1;
    endfunction

    function automatic modexp_out_t power_mod(input modexp_in_t x);
        logic [63:0] mbits, sgn, m, aux, e, ans, r, b, p;
        modexp_out_t res;
        res = '0;
        b = x.base_value;
        p = x.power;
        mbits = 64'(unsigned'(x.divisor_modulus)) & ((64'd1 << MOD_WIDTH) - 64'd1);
        sgn = 64'd1 << (MOD_WIDTH - 1);
        m = (mbits & sgn) != 0 ? (sgn << 1) - mbits : mbits;
        if (m == 0) begin
            res.error_flag = 1'b1;
            return res;
        end
        if (b[63]) begin
            r = (64'd0 - b) % m;
            aux = (r != 0) ? m - r : 64'd0;
        end else begin
            aux = b % m;
        end
        if (p[63]) begin
            e = 64'd0 - p;
            if (m == 1) begin
                aux = 64'd1;
            end else if (!modinv(aux, m, aux)) begin
                res.error_flag = 1'b1;
                return res;
            end
        end else begin
            e = p;
        end
        ans = 64'd1;
        while (e != 0) begin
            if (e[0]) ans = (ans * aux) % m;
            e = e >> 1;
            aux = (aux * aux) % m;
        end
        res.residue = ans[RES_W-1:0];
        return res;
    endfunction

    assign pending = residue_queue.size();

    always @(posedge aclk) begin
        modexp_out_t exp_res;
        int errs;
        errs = 0;
        if (!aresetn) begin
            fail_count <= 0;
            results_seen <= 0;
            errors_seen <= 0;
        end else begin
            if (s_valid && s_ready) residue_queue.push_back(power_mod(s_data));
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (m_data.error_flag) errors_seen <= errors_seen + 1;
                if (residue_queue.size() == 0) begin
                    $error("unexpected result transfer: residue %0d error_flag %0b",
                           m_data.residue, m_data.error_flag);
                    errs++;
                end else begin
                    exp_res = residue_queue.pop_front();
                    if (m_data.residue !== exp_res.residue) begin
                        $error("residue: expected %0d, got %0d",
                               exp_res.residue, m_data.residue);
                        errs++;
                    end
                    if (m_data.error_flag !== exp_res.error_flag) begin
                        $error("error_flag: expected %0b, got %0b",
                               exp_res.error_flag, m_data.error_flag);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

// ----- bench/tb.sv -----
module tb;
    import modexp_pkg::*;

    localparam int LIMIT = 6000000;
    localparam int RANDOM_ITEMS = 100;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    modexp_in_t  s_data;
    logic        m_valid;
    logic        m_ready;
    modexp_out_t m_data;

    int fail_count, pending, results_seen, errors_seen;
    int items_sent;
    int cycles = 0;
    bit stimulus_done;

    modular_exponentiation_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    modexp_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending),
        .results_seen(results_seen), .errors_seen(errors_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Quiet stretch on both sides while cycles is in this window.
    function automatic bit quiet_window();
        return cycles > 30000 && cycles < 90000;
    endfunction

    // Receiver: random stalls, plus one long hold-off so the input backs up.
    initial begin
        int n;
        bit held;
        n = 0;
        held = 0;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held && results_seen >= 8) begin
                held = 1;
                m_ready <= 1'b0;
                for (n = 0; n < 25000; n++) @(posedge aclk);
            end
            m_ready <= quiet_window() || ($urandom_range(99) >= 21);
            @(posedge aclk);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Drive one item; hold valid and payload until the transfer.
    task automatic send_item(input modexp_in_t x);
        int gap;
        if (!quiet_window() && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 40);
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send3(input logic [63:0] b, input logic [63:0] p, input logic [31:0] m);
        modexp_in_t x;
        x.base_value = b;
        x.power = p;
        x.divisor_modulus = m;
        send_item(x);
    endtask

    initial begin
        modexp_in_t x;
        int k, w;
        logic [63:0] mask;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        items_sent = 0;
        stimulus_done = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero modulus
        send3(64'd5, 64'd3, 32'd0);
        send3(64'd5, 64'd0, 32'd0);
        // zero power, including modulus of magnitude one
        send3(64'd7, 64'd0, 32'd1);
        send3(64'd7, 64'd0, -32'sd13);
        // modulus one and minus one
        send3(64'd7, 64'd5, 32'd1);
        send3(64'd7, -64'sd5, -32'sd1);
        // inverse path, and non-invertible bases
        send3(64'd3, -64'sd1, 32'd7);
        send3(64'd4, -64'sd3, 32'd8);
        send3(64'd14, -64'sd2, 32'd7);
        send3(-64'sd3, -64'sd5, 32'd1000003);
        // extremes of the base
        send3(64'h8000_0000_0000_0000, 64'd3, 32'd97);
        send3(64'h7fff_ffff_ffff_ffff, 64'd65537, 32'h7fff_ffff);
        send3(64'hffff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, 32'h7fff_ffff);
        // most negative modulus and power
        send3(64'd3, 64'd100, 32'h8000_0000);
        send3(64'd3, 64'h8000_0000_0000_0000, 32'd1000000007);
        send3(64'd2, -64'sh7fff_ffff_ffff_ffff, -32'sh7fff_ffff);
        send3(64'd0, 64'd0, 32'd5);
        send3(64'd0, 64'd9, 32'd5);
        send3(64'd12345, 64'hffff_ffff_ffff_ffff, 32'h8000_0001);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            x.base_value = rand64();
            case ($urandom_range(3))
                0: x.divisor_modulus = $urandom_range(1, 40);
                1: x.divisor_modulus = -$urandom_range(1, 40);
                default: x.divisor_modulus = $urandom;
            endcase
            if ($urandom_range(19) == 0) x.divisor_modulus = 0;
            if ($urandom_range(9) == 0) x.base_value = x.divisor_modulus * $urandom_range(3);
            // mostly short exponents keep the run short; a few use all 64 bits
            if ($urandom_range(9) == 0) begin
                x.power = rand64();
            end else begin
                w = $urandom_range(0, 16);
                mask = (64'd1 << w) - 64'd1;
                x.power = rand64() & mask;
                if ($urandom_range(1)) x.power = -x.power;
            end
            send_item(x);
        end
        s_valid <= 1'b0;
        stimulus_done = 1;
    end

    initial begin
        wait (stimulus_done);
        while (pending != 0) @(posedge aclk);
        repeat (12000) @(posedge aclk);
        $display("Sent %0d items, checked %0d results, %0d of them flagged as errors.",
                 items_sent, results_seen, errors_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
